FILE: design/prls_pkg.sv
// package for the priority ready list scheduler
// item layouts, status codes and controller/datapath command and status types
// no dependencies
package prls_pkg;

   localparam int ENTRY_W = 16;
   localparam int PRIO_W = 8;
   localparam int STATUS_W = 2;
   localparam int SLOT_FIELD_W = 3;

   typedef logic [ENTRY_W-1:0] entry_type;
   typedef logic [PRIO_W-1:0] prio_type;
   typedef logic [SLOT_FIELD_W-1:0] slot_field_type;

   localparam logic REQ_ACTIVATE = 1'b0;
   localparam logic REQ_TERMINATE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK = 2'd0,
      STATUS_NO_FREE = 2'd1,
      STATUS_NO_TASK = 2'd2
   } status_type;

   typedef struct packed {
      logic req_type;
      entry_type task_entry;
      prio_type task_priority;
   } req_item_type;

   typedef struct packed {
      status_type status;
      slot_field_type slot_used;
      logic run_changed;
      logic ready_empty;
      slot_field_type run_slot;
      entry_type run_entry;
      prio_type run_priority;
   } rsp_item_type;

   typedef enum logic [1:0] {
      RD_FREE_HEAD,
      RD_READY_HEAD,
      RD_LINK_OUT
   } rd_sel_type;

   typedef struct packed {
      logic load_req;
      rd_sel_type rd_sel;
      logic alloc;
      logic walk_step;
      logic link_new;
      logic link_prev;
      logic retire;
      logic load_rsp;
      status_type status;
   } ctrl_cmd_type;

   typedef struct packed {
      logic in_terminate;
      logic free_null;
      logic head_null;
      logic walk_stop;
      logic link_null;
      logic prev_null;
   } dp_status_type;

endpackage

FILE: design/prls_req_if.sv
// request channel of the priority ready list scheduler
// valid/ready handshake with the request fields, widths from prls_pkg
interface prls_req_if;
   logic valid;
   logic ready;
   logic req_type;
   logic [prls_pkg::ENTRY_W-1:0] task_entry;
   logic [prls_pkg::PRIO_W-1:0] task_priority;

   modport source (output valid, req_type, task_entry, task_priority, input ready);
   modport sink (input valid, req_type, task_entry, task_priority, output ready);
endinterface

FILE: design/prls_rsp_if.sv
// response channel of the priority ready list scheduler
// valid/ready handshake with the result fields, widths from prls_pkg
interface prls_rsp_if;
   logic valid;
   logic ready;
   logic [prls_pkg::STATUS_W-1:0] status;
   logic [prls_pkg::SLOT_FIELD_W-1:0] slot_used;
   logic run_changed;
   logic ready_empty;
   logic [prls_pkg::SLOT_FIELD_W-1:0] run_slot;
   logic [prls_pkg::ENTRY_W-1:0] run_entry;
   logic [prls_pkg::PRIO_W-1:0] run_priority;

   modport source (output valid, status, slot_used, run_changed, ready_empty, run_slot,
                   run_entry, run_priority, input ready);
   modport sink (input valid, status, slot_used, run_changed, ready_empty, run_slot,
                 run_entry, run_priority, output ready);
endinterface

FILE: design/prls_datapath.sv
// datapath of the priority ready list scheduler: list heads, walk pointers,
// link/priority/entry memories and the response register; uses prls_pkg
module prls_datapath #(
   parameter int MAX_TASKS = 8
) (
   input logic clock,
   input logic reset,
   input prls_pkg::req_item_type req_item,
   input prls_pkg::ctrl_cmd_type cmd,
   output prls_pkg::dp_status_type stat,
   output prls_pkg::rsp_item_type rsp_item
);

   localparam int SW = $clog2(MAX_TASKS + 1);
   localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam logic [SW-1:0] NULL_SLOT = SW'(MAX_TASKS);

   logic [SW-1:0] ready_head_ff;
   logic [SW-1:0] free_head_ff;
   logic [SW-1:0] old_head_ff;
   logic [SW-1:0] slot_ff;
   logic [SW-1:0] cur_ff;
   logic [SW-1:0] prev_ff;
   prls_pkg::req_item_type req_ff;
   logic [MAX_TASKS-1:0] link_valid_ff;
   logic [SW-1:0] rd_link_ff;
   prls_pkg::prio_type rd_prio_ff;
   prls_pkg::entry_type rd_entry_ff;
   prls_pkg::rsp_item_type rsp_ff;

   logic [SW-1:0] link_mem [MAX_TASKS];
   prls_pkg::prio_type prio_mem [MAX_TASKS];
   prls_pkg::entry_type entry_mem [MAX_TASKS];

   logic [SW-1:0] rd_addr;
   logic [IW-1:0] rd_idx;
   logic link_we;
   logic [SW-1:0] link_wa;
   logic [SW-1:0] link_wd;
   logic [IW-1:0] link_widx;
   logic [IW-1:0] alloc_idx;

   always_comb begin
      case (cmd.rd_sel)
         prls_pkg::RD_FREE_HEAD: rd_addr = free_head_ff;
         prls_pkg::RD_LINK_OUT: rd_addr = rd_link_ff;
         default: rd_addr = ready_head_ff;
      endcase
   end

   assign rd_idx = rd_addr[IW-1:0];
   assign alloc_idx = free_head_ff[IW-1:0];

   always_comb begin
      link_we = 1'b0;
      link_wa = slot_ff;
      link_wd = cur_ff;
      if (cmd.link_new) begin
         link_we = 1'b1;
      end else if (cmd.link_prev) begin
         link_we = 1'b1;
         link_wa = prev_ff;
         link_wd = slot_ff;
      end else if (cmd.retire) begin
         link_we = 1'b1;
         link_wa = ready_head_ff;
         link_wd = free_head_ff;
      end
   end

   assign link_widx = link_wa[IW-1:0];

   // memories
   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_widx] <= link_wd;
      end
      if (cmd.alloc) begin
         prio_mem[alloc_idx] <= req_ff.task_priority;
         entry_mem[alloc_idx] <= req_ff.task_entry;
      end
      // unwritten links read as their reset chain
      rd_link_ff <= link_valid_ff[rd_idx] ? link_mem[rd_idx] : SW'(rd_addr + 1'b1);
      rd_prio_ff <= prio_mem[rd_idx];
      rd_entry_ff <= entry_mem[rd_idx];
   end

   // list heads and link valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         ready_head_ff <= NULL_SLOT;
         free_head_ff <= '0;
         link_valid_ff <= '0;
      end else begin
         if (link_we) begin
            link_valid_ff[link_widx] <= 1'b1;
         end
         if (cmd.alloc) begin
            free_head_ff <= rd_link_ff;
         end
         if (cmd.link_new && (prev_ff == NULL_SLOT)) begin
            ready_head_ff <= slot_ff;
         end
         if (cmd.retire) begin
            ready_head_ff <= rd_link_ff;
            free_head_ff <= ready_head_ff;
         end
      end
   end

   // walk pointers and request payload
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_item;
         old_head_ff <= ready_head_ff;
      end
      if (cmd.alloc) begin
         slot_ff <= free_head_ff;
         cur_ff <= ready_head_ff;
         prev_ff <= NULL_SLOT;
      end
      if (cmd.walk_step) begin
         prev_ff <= cur_ff;
         cur_ff <= rd_link_ff;
      end
      if (cmd.retire) begin
         slot_ff <= ready_head_ff;
      end
      if (cmd.load_rsp) begin
         rsp_ff.status <= cmd.status;
         rsp_ff.slot_used <= (cmd.status == prls_pkg::STATUS_OK) ?
                             prls_pkg::slot_field_type'(slot_ff) : '0;
         rsp_ff.run_changed <= (ready_head_ff != old_head_ff);
         rsp_ff.ready_empty <= (ready_head_ff == NULL_SLOT);
         if (ready_head_ff == NULL_SLOT) begin
            rsp_ff.run_slot <= '0;
            rsp_ff.run_entry <= '0;
            rsp_ff.run_priority <= '0;
         end else begin
            rsp_ff.run_slot <= prls_pkg::slot_field_type'(ready_head_ff);
            rsp_ff.run_entry <= rd_entry_ff;
            rsp_ff.run_priority <= rd_prio_ff;
         end
      end
   end

   assign stat.in_terminate = (req_item.req_type == prls_pkg::REQ_TERMINATE);
   assign stat.free_null = (free_head_ff == NULL_SLOT);
   assign stat.head_null = (ready_head_ff == NULL_SLOT);
   assign stat.walk_stop = (rd_prio_ff < req_ff.task_priority);
   assign stat.link_null = (rd_link_ff == NULL_SLOT);
   assign stat.prev_null = (prev_ff == NULL_SLOT);

   assign rsp_item = rsp_ff;

endmodule

FILE: design/prls_ctrl.sv
// controller of the priority ready list scheduler: sequences accept, allocate,
// sorted walk, relink, terminate and response; uses prls_pkg
module prls_ctrl (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input logic rsp_ready,
   input prls_pkg::dp_status_type stat,
   output prls_pkg::ctrl_cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_ALLOC,
      S_WALK,
      S_LINK,
      S_PREV,
      S_TERM,
      S_HEAD_RD,
      S_RESP
   } state_type;

   state_type state_ff, state_in;
   prls_pkg::status_type status_ff, status_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      status_in = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd = '0;
      cmd.rd_sel = prls_pkg::RD_READY_HEAD;
      cmd.status = status_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               status_in = prls_pkg::STATUS_OK;
               if (stat.in_terminate) begin
                  if (stat.head_null) begin
                     status_in = prls_pkg::STATUS_NO_TASK;
                     state_in = S_HEAD_RD;
                  end else begin
                     state_in = S_TERM;
                  end
               end else if (stat.free_null) begin
                  status_in = prls_pkg::STATUS_NO_FREE;
                  state_in = S_HEAD_RD;
               end else begin
                  cmd.rd_sel = prls_pkg::RD_FREE_HEAD;
                  state_in = S_ALLOC;
               end
            end
         end
         S_ALLOC: begin
            cmd.alloc = 1'b1;
            state_in = stat.head_null ? S_LINK : S_WALK;
         end
         S_WALK: begin
            if (stat.walk_stop) begin
               state_in = S_LINK;
            end else begin
               cmd.walk_step = 1'b1;
               cmd.rd_sel = prls_pkg::RD_LINK_OUT;
               if (stat.link_null) begin
                  state_in = S_LINK;
               end
            end
         end
         S_LINK: begin
            cmd.link_new = 1'b1;
            state_in = stat.prev_null ? S_HEAD_RD : S_PREV;
         end
         S_PREV: begin
            cmd.link_prev = 1'b1;
            state_in = S_HEAD_RD;
         end
         S_TERM: begin
            cmd.retire = 1'b1;
            state_in = S_HEAD_RD;
         end
         S_HEAD_RD: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         status_ff <= prls_pkg::STATUS_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         status_ff <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: design/priority_ready_list_scheduler.sv
// Priority ready list scheduler: a pool of MAX_TASKS task slots kept as a LIFO
// free list and a ready list sorted by descending priority (equal priorities in
// arrival order); the head is the running task. One request is worked at a time
// and every request gives one response. An activate runs allocate, a sorted walk
// over the ready tasks it is compared with (at most MAX_TASKS - 1), the link and,
// if the new task is not placed at the head, a relink of its predecessor; a
// terminate runs retire; then each request reads the head and loads its response.
// The walk visits one list entry per cycle through the single link memory read port.
// A finished response sits in an output register while the next request is taken.
// Depends on prls_pkg, prls_req_if, prls_rsp_if, prls_ctrl and prls_datapath.
module priority_ready_list_scheduler #(
   parameter int MAX_TASKS = 8
) (
   input logic clock,
   input logic reset,
   prls_req_if.sink req_ch,
   prls_rsp_if.source rsp_ch
);

   prls_pkg::req_item_type req_item;
   prls_pkg::rsp_item_type rsp_item;
   prls_pkg::ctrl_cmd_type cmd;
   prls_pkg::dp_status_type stat;

   assign req_item.req_type = req_ch.req_type;
   assign req_item.task_entry = req_ch.task_entry;
   assign req_item.task_priority = req_ch.task_priority;

   prls_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat (stat),
      .cmd (cmd)
   );

   prls_datapath #(
      .MAX_TASKS (MAX_TASKS)
   ) u_datapath (
      .clock (clock),
      .reset (reset),
      .req_item (req_item),
      .cmd (cmd),
      .stat (stat),
      .rsp_item (rsp_item)
   );

   assign rsp_ch.status = rsp_item.status;
   assign rsp_ch.slot_used = rsp_item.slot_used;
   assign rsp_ch.run_changed = rsp_item.run_changed;
   assign rsp_ch.ready_empty = rsp_item.ready_empty;
   assign rsp_ch.run_slot = rsp_item.run_slot;
   assign rsp_ch.run_entry = rsp_item.run_entry;
   assign rsp_ch.run_priority = rsp_item.run_priority;

endmodule

FILE: design/prls_checker.sv
// port level checks for the priority ready list scheduler and their bind
// depends on prls_pkg and priority_ready_list_scheduler
module prls_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [prls_pkg::STATUS_W-1:0] status,
   input logic [prls_pkg::SLOT_FIELD_W-1:0] slot_used,
   input logic run_changed,
   input logic ready_empty,
   input logic [prls_pkg::SLOT_FIELD_W-1:0] run_slot,
   input logic [prls_pkg::ENTRY_W-1:0] run_entry,
   input logic [prls_pkg::PRIO_W-1:0] run_priority
);

   // one item in flight
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another item is in flight");

   a_empty_run_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ready_empty |-> run_slot == '0 && run_entry == '0 && run_priority == '0)
      else $error("run fields not cleared on empty ready list");

   a_error_no_change: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status != prls_pkg::STATUS_OK |-> !run_changed && slot_used == '0)
      else $error("rejected request reports a change");

   a_no_task_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status == prls_pkg::STATUS_NO_TASK |-> ready_empty)
      else $error("terminate rejected while tasks are ready");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(run_entry))
      else $error("stalled item changed");

endmodule

bind priority_ready_list_scheduler prls_checker u_prls_checker (
   .clock (clock),
   .reset (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .status (rsp_ch.status),
   .slot_used (rsp_ch.slot_used),
   .run_changed (rsp_ch.run_changed),
   .ready_empty (rsp_ch.ready_empty),
   .run_slot (rsp_ch.run_slot),
   .run_entry (rsp_ch.run_entry),
   .run_priority (rsp_ch.run_priority)
);

FILE: tb/priority_ready_list_scheduler_tb.sv
// testbench for priority_ready_list_scheduler: drives activate and terminate items,
// predicts each response from its own copy of the free list and sorted ready list
// depends on prls_pkg, prls_req_if, prls_rsp_if and the scheduler rtl
`timescale 1ns / 1ps

module priority_ready_list_scheduler_tb;

   localparam int SLOTS = 8;
   localparam logic [3:0] NIL = 4'(SLOTS);
   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_CYCLES = 250;
   localparam int RANDOM_ITEMS = 520;

   logic clock = 1'b0;
   logic reset;

   prls_req_if req_bus();
   prls_rsp_if rsp_bus();

   priority_ready_list_scheduler #(.MAX_TASKS(SLOTS)) DUT (
      .clock(clock),
      .reset(reset),
      .req_ch(req_bus),
      .rsp_ch(rsp_bus)
   );

   always #6 clock = ~clock;

   // predicted scheduler state
   logic [3:0] sched_head;
   logic [3:0] sched_free;
   logic [3:0] sched_link [SLOTS];
   prls_pkg::prio_type sched_prio [SLOTS];
   prls_pkg::entry_type sched_entry [SLOTS];
   int ready_count;

   prls_pkg::rsp_item_type outcome_q[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_asks = 0;
   int hold_taken = 0;
   int hold_left = 0;
   int stall_cycles = 0;
   int mismatches = 0;
   int checked = 0;
   int n_activate = 0;
   int n_terminate = 0;
   int n_pool_full = 0;
   int n_list_empty = 0;
   int n_head_change = 0;

   function void sched_reset();
      for (int i = 0; i < SLOTS; i++) begin
         sched_link[i] = 4'(i + 1);
         sched_prio[i] = '0;
         sched_entry[i] = '0;
      end
      sched_head = NIL;
      sched_free = '0;
      ready_count = 0;
   endfunction

   function prls_pkg::rsp_item_type sched_apply(prls_pkg::req_item_type rq);
      prls_pkg::rsp_item_type r;
      logic [3:0] slot;
      logic [3:0] cur;
      logic [3:0] prev;
      logic [3:0] old_head;
      r = '0;
      r.status = prls_pkg::STATUS_OK;
      old_head = sched_head;
      if (rq.req_type == prls_pkg::REQ_ACTIVATE) begin
         if (sched_free == NIL) begin
            r.status = prls_pkg::STATUS_NO_FREE;
            n_pool_full++;
         end else begin
            slot = sched_free;
            sched_free = sched_link[slot[2:0]];
            sched_prio[slot[2:0]] = rq.task_priority;
            sched_entry[slot[2:0]] = rq.task_entry;
            // walk past every task of equal or higher priority
            cur = sched_head;
            prev = NIL;
            while (cur != NIL && sched_prio[cur[2:0]] >= rq.task_priority) begin
               prev = cur;
               cur = sched_link[cur[2:0]];
            end
            sched_link[slot[2:0]] = cur;
            if (prev == NIL) sched_head = slot;
            else sched_link[prev[2:0]] = slot;
            r.slot_used = slot[2:0];
            r.run_changed = (sched_head != old_head);
            ready_count++;
            n_activate++;
         end
      end else begin
         if (sched_head == NIL) begin
            r.status = prls_pkg::STATUS_NO_TASK;
            n_list_empty++;
         end else begin
            slot = sched_head;
            sched_head = sched_link[slot[2:0]];
            sched_link[slot[2:0]] = sched_free;
            sched_free = slot;
            r.slot_used = slot[2:0];
            r.run_changed = 1'b1;
            ready_count--;
            n_terminate++;
         end
      end
      if (sched_head == NIL) begin
         r.ready_empty = 1'b1;
      end else begin
         r.run_slot = sched_head[2:0];
         r.run_entry = sched_entry[sched_head[2:0]];
         r.run_priority = sched_prio[sched_head[2:0]];
      end
      if (r.run_changed) n_head_change++;
      return r;
   endfunction

   task automatic issue(input logic kind, input prls_pkg::entry_type ent,
                        input prls_pkg::prio_type pr);
      prls_pkg::req_item_type rq;
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
      @(negedge clock);
      req_bus.valid <= 1'b1;
      req_bus.req_type <= kind;
      req_bus.task_entry <= ent;
      req_bus.task_priority <= pr;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      rq.req_type = kind;
      rq.task_entry = ent;
      rq.task_priority = pr;
      outcome_q.push_back(sched_apply(rq));
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (outcome_q.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      issue(prls_pkg::REQ_TERMINATE, 16'hFFFF, 8'hFF);
      issue(prls_pkg::REQ_ACTIVATE, 16'h0000, 8'h00);
      issue(prls_pkg::REQ_ACTIVATE, 16'hFFFF, 8'hFF);
      issue(prls_pkg::REQ_ACTIVATE, 16'h1234, 8'hFF);
      issue(prls_pkg::REQ_ACTIVATE, 16'hA5A5, 8'h00);
      issue(prls_pkg::REQ_ACTIVATE, 16'h5A5A, 8'h80);
      issue(prls_pkg::REQ_ACTIVATE, 16'h00FF, 8'h7F);
      issue(prls_pkg::REQ_ACTIVATE, 16'hFF00, 8'h80);
      issue(prls_pkg::REQ_ACTIVATE, 16'h8001, 8'h01);
      // pool full
      issue(prls_pkg::REQ_ACTIVATE, 16'hFFFF, 8'hFF);
      issue(prls_pkg::REQ_ACTIVATE, 16'h0000, 8'h00);
      for (int i = 0; i < SLOTS; i++)
         issue(prls_pkg::REQ_TERMINATE, (i % 2) ? 16'hFFFF : 16'h0000,
               (i % 2) ? 8'h00 : 8'hFF);
      issue(prls_pkg::REQ_TERMINATE, 16'h0000, 8'h00);
      wait_drained();
   endtask

   task automatic test_random(input int count, input int s_pct, input int r_pct);
      int depth_goal;
      int act_pct;
      prls_pkg::prio_type pr;
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      depth_goal = 0;
      for (int k = 0; k < count; k++) begin
         if (k % 40 == 0) depth_goal = $urandom_range(0, SLOTS);
         act_pct = (ready_count < depth_goal) ? 80 : 25;
         if ($urandom_range(99) < act_pct) begin
            case ($urandom_range(3))
               0: pr = prls_pkg::prio_type'($urandom_range(0, 3));
               1: pr = $urandom_range(1) ? 8'hFF : 8'h00;
               default: pr = prls_pkg::prio_type'($urandom);
            endcase
            issue(prls_pkg::REQ_ACTIVATE, prls_pkg::entry_type'($urandom), pr);
         end else begin
            issue(prls_pkg::REQ_TERMINATE, prls_pkg::entry_type'($urandom),
                  prls_pkg::prio_type'($urandom));
         end
      end
      wait_drained();
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_asks++;
      for (int i = 0; i < 12; i++) begin
         if (i % 3 == 2)
            issue(prls_pkg::REQ_TERMINATE, prls_pkg::entry_type'($urandom),
                  prls_pkg::prio_type'($urandom));
         else
            issue(prls_pkg::REQ_ACTIVATE, prls_pkg::entry_type'($urandom),
                  prls_pkg::prio_type'($urandom_range(0, 3)));
      end
      wait_drained();
      for (int i = 0; i < 6; i++)
         issue(prls_pkg::REQ_TERMINATE, prls_pkg::entry_type'($urandom),
               prls_pkg::prio_type'($urandom));
      wait_drained();
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(negedge clock) begin
      if (hold_asks != hold_taken) begin
         hold_taken = hold_asks;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : check_outcomes
      prls_pkg::rsp_item_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (outcome_q.size() == 0) begin
            $display("%0t: unexpected item, expected none, actual status %0h slot %0h",
                     $time, rsp_bus.status, rsp_bus.slot_used);
            mismatches++;
         end else begin
            want = outcome_q.pop_front();
            check_field("status", want.status, rsp_bus.status);
            check_field("slot_used", want.slot_used, rsp_bus.slot_used);
            check_field("run_changed", want.run_changed, rsp_bus.run_changed);
            check_field("ready_empty", want.ready_empty, rsp_bus.ready_empty);
            check_field("run_slot", want.run_slot, rsp_bus.run_slot);
            check_field("run_entry", want.run_entry, rsp_bus.run_entry);
            check_field("run_priority", want.run_priority, rsp_bus.run_priority);
            checked++;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
         $display("priority_ready_list_scheduler regression: fail");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.req_type = prls_pkg::REQ_ACTIVATE;
      req_bus.task_entry = '0;
      req_bus.task_priority = '0;
      rsp_bus.ready = 1'b0;
      sched_reset();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_random(RANDOM_ITEMS, 22, 87);
      test_backpressure();
      test_random(RANDOM_ITEMS, 87, 22);
      test_random(RANDOM_ITEMS, 0, 0);

      @(negedge clock);
      req_bus.valid <= 1'b0;
      wait_drained();
      repeat (40) @(posedge clock);

      $display("covered %0d activations, %0d terminations, %0d head changes",
               n_activate, n_terminate, n_head_change);
      $display("%0d pool-full and %0d empty-list rejects, %0d items checked",
               n_pool_full, n_list_empty, checked);
      if (mismatches == 0 && outcome_q.size() == 0)
         $display("priority_ready_list_scheduler regression: pass");
      else
         $display("priority_ready_list_scheduler regression: fail");
      $finish;
   end

endmodule
